// ===== sv/assert_macros.svh =====
// Assertion macros shared by the slot table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ===== sv/stf_pkg.sv =====
// Constants and types shared by the slot table modules.
package stf_pkg;

   localparam int SLOT_COUNT = 8;
   localparam int ID_WIDTH   = 16;
   localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W      = 4;

   localparam logic [3:0] CMD_ADD       = 4'd0;
   localparam logic [3:0] CMD_ADD_AT    = 4'd1;
   localparam logic [3:0] CMD_MOVE      = 4'd2;
   localparam logic [3:0] CMD_SWAP      = 4'd3;
   localparam logic [3:0] CMD_REMOVE_AT = 4'd4;
   localparam logic [3:0] CMD_REMOVE_ID = 4'd5;
   localparam logic [3:0] CMD_FIND      = 4'd6;
   localparam logic [3:0] CMD_READ_SLOT = 4'd7;
   localparam logic [3:0] CMD_CLEAR     = 4'd8;

   typedef logic [ID_WIDTH-1:0] id_type;
   typedef logic [IDX_W-1:0]    idx_type;

   typedef struct packed {
      logic    en;
      idx_type addr;
      id_type  data;
   } wr_req_type;

endpackage

// ===== sv/slot_table_first_free_top.sv =====
// Slot table with first-free allocation, scanned by one shared compare unit.
//
// One command enters on the req channel; one result leaves on the rsp channel.
// req_tuser carries the command code, req_tdata the identifier and two slot
// indexes. rsp_tdata carries ok, the slot index, the identifier that was read
// or removed, and the count of empty slots after the command.
// After a command is accepted, the table is scanned one slot per cycle through
// a single RAM read port and one identifier compare, a drain state empties the
// read pipeline, an execute state writes any update back through the single RAM
// write port (a move or swap that rewrites two slots takes a second write state),
// and the result register is loaded, raising rsp_tvalid. req_tready is high only
// while no command is in work, so a new command is not accepted until the
// previous result has left the sequencer.
// A new command may be accepted while the previous result still waits in the
// output register; its result then stays in the sequencer until the old one
// is transferred. When rsp_tready is low the result register simply holds.
// Reset empties every slot at once through per-slot valid bits; no clearing
// pass is needed and a command can be accepted as soon as reset is released.
`include "assert_macros.svh"
module slot_table_first_free_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // unit_id[15:0], index_a[19:16], index_b[23:20]
   input  logic [3:0]  req_tuser,  // command[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // ok[0], slot_index[4:1], unit_id_out[20:5],
                                   // empty_count[24:21], zero[31:25]
);

   localparam int IdW  = stf_pkg::ID_WIDTH;
   localparam int IdxW = stf_pkg::IDX_W;
   localparam int CntW = stf_pkg::CNT_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_EXEC  = 3'd3;
   localparam logic [2:0] ST_WR2   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [3:0]                     cmd_ff;
   stf_pkg::id_type                id_ff;
   logic [3:0]                     a_ff, b_ff;
   stf_pkg::idx_type               ptr_ff;
   logic                           cmp_vld_ff;
   stf_pkg::idx_type               cmp_idx_ff;
   logic                           rd_vld_ff;
   logic [stf_pkg::SLOT_COUNT-1:0] valid_ff;
   stf_pkg::id_type                val_a_ff, val_b_ff;
   logic                           free_found_ff, match_found_ff;
   stf_pkg::idx_type               free_idx_ff, match_idx_ff;
   logic [CntW-1:0]                empty_ff;
   logic                           ok_ff;
   logic [3:0]                     sidx_ff;
   stf_pkg::id_type                idout_ff;
   stf_pkg::wr_req_type            wr2_ff;
   logic                           rsp_valid_ff;
   logic [31:0]                    rsp_data_ff;

   stf_pkg::id_type                rd_data;
   stf_pkg::id_type                slot_val;
   logic                           is_free, is_hit;
   logic                           a_ok, b_ok;
   logic                           ok_c, clear_c;
   logic [3:0]                     sidx_c;
   stf_pkg::id_type                idout_c;
   stf_pkg::wr_req_type            wr1_c, wr2_c, wr_port;
   logic                           dec_c, inc_c;
   logic                           req_fire, load_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign load_rsp   = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // Shared compare unit: one slot per cycle, invalid slots read as empty.
   assign slot_val = rd_vld_ff ? rd_data : '0;
   assign is_free  = (slot_val == '0);
   assign is_hit   = (id_ff != '0) && (slot_val == id_ff);

   assign a_ok = (a_ff < 4'(stf_pkg::SLOT_COUNT));
   assign b_ok = (b_ff < 4'(stf_pkg::SLOT_COUNT));

   always_comb begin
      ok_c    = 1'b0;
      clear_c = 1'b0;
      sidx_c  = '0;
      idout_c = '0;
      dec_c   = 1'b0;
      inc_c   = 1'b0;
      wr1_c   = '0;
      wr2_c   = '0;
      case (cmd_ff)
         stf_pkg::CMD_ADD: begin
            if ((id_ff != '0) && !match_found_ff && free_found_ff) begin
               ok_c   = 1'b1;
               sidx_c = 4'(free_idx_ff);
               dec_c  = 1'b1;
               wr1_c  = '{en: 1'b1, addr: free_idx_ff, data: id_ff};
            end
         end
         stf_pkg::CMD_ADD_AT: begin
            if ((id_ff != '0) && a_ok && (val_a_ff == '0) && !match_found_ff) begin
               ok_c   = 1'b1;
               sidx_c = a_ff;
               dec_c  = 1'b1;
               wr1_c  = '{en: 1'b1, addr: a_ff[IdxW-1:0], data: id_ff};
            end
         end
         stf_pkg::CMD_MOVE: begin
            if (a_ok && b_ok && (val_a_ff != '0)) begin
               if (a_ff == b_ff) begin
                  ok_c = 1'b1;
               end else if (val_b_ff == '0) begin
                  ok_c  = 1'b1;
                  wr1_c = '{en: 1'b1, addr: b_ff[IdxW-1:0], data: val_a_ff};
                  wr2_c = '{en: 1'b1, addr: a_ff[IdxW-1:0], data: '0};
               end
            end
         end
         stf_pkg::CMD_SWAP: begin
            if (a_ok && b_ok) begin
               if (a_ff == b_ff) begin
                  ok_c = (val_a_ff != '0);
               end else if ((val_a_ff != '0) || (val_b_ff != '0)) begin
                  ok_c  = 1'b1;
                  wr1_c = '{en: 1'b1, addr: a_ff[IdxW-1:0], data: val_b_ff};
                  wr2_c = '{en: 1'b1, addr: b_ff[IdxW-1:0], data: val_a_ff};
               end
            end
         end
         stf_pkg::CMD_REMOVE_AT: begin
            if (a_ok) begin
               ok_c    = (val_a_ff != '0);
               idout_c = val_a_ff;
               inc_c   = (val_a_ff != '0);
               wr1_c   = '{en: 1'b1, addr: a_ff[IdxW-1:0], data: '0};
            end
         end
         stf_pkg::CMD_REMOVE_ID: begin
            if (match_found_ff) begin
               ok_c    = 1'b1;
               idout_c = id_ff;
               inc_c   = 1'b1;
               wr1_c   = '{en: 1'b1, addr: match_idx_ff, data: '0};
            end
         end
         stf_pkg::CMD_FIND: begin
            if (match_found_ff) begin
               ok_c   = 1'b1;
               sidx_c = 4'(match_idx_ff);
            end
         end
         stf_pkg::CMD_READ_SLOT: begin
            if (a_ok) begin
               ok_c    = 1'b1;
               idout_c = val_a_ff;
            end
         end
         stf_pkg::CMD_CLEAR: begin
            ok_c    = 1'b1;
            clear_c = 1'b1;
         end
         default: begin
            ok_c = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_port = '0;
      if (state_ff == ST_EXEC) begin
         wr_port = wr1_c;
      end else if (state_ff == ST_WR2) begin
         wr_port = wr2_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ptr_ff == IdxW'(stf_pkg::SLOT_COUNT - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_EXEC;
         ST_EXEC:  state_in = wr2_c.en ? ST_WR2 : ST_DONE;
         ST_WR2:   state_in = ST_DONE;
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         empty_ff     <= CntW'(stf_pkg::SLOT_COUNT);
         rsp_valid_ff <= 1'b0;
         wr2_ff       <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= (state_ff == ST_SCAN);
         if (wr_port.en) begin
            valid_ff[wr_port.addr] <= 1'b1;
         end
         if (state_ff == ST_EXEC) begin
            wr2_ff <= wr2_c;
            if (clear_c) begin
               valid_ff <= '0;
               empty_ff <= CntW'(stf_pkg::SLOT_COUNT);
            end else if (dec_c) begin
               empty_ff <= empty_ff - 1'b1;
            end else if (inc_c) begin
               empty_ff <= empty_ff + 1'b1;
            end
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff         <= req_tuser;
         id_ff          <= IdW'(req_tdata[15:0]);
         a_ff           <= req_tdata[19:16];
         b_ff           <= req_tdata[23:20];
         ptr_ff         <= '0;
         val_a_ff       <= '0;
         val_b_ff       <= '0;
         free_found_ff  <= 1'b0;
         match_found_ff <= 1'b0;
         free_idx_ff    <= '0;
         match_idx_ff   <= '0;
      end else if (state_ff == ST_SCAN) begin
         ptr_ff <= ptr_ff + 1'b1;
      end
      rd_vld_ff  <= valid_ff[ptr_ff];
      cmp_idx_ff <= ptr_ff;
      if (cmp_vld_ff) begin
         if (is_free && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= cmp_idx_ff;
         end
         if (is_hit && !match_found_ff) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= cmp_idx_ff;
         end
         if (4'(cmp_idx_ff) == a_ff) begin
            val_a_ff <= slot_val;
         end
         if (4'(cmp_idx_ff) == b_ff) begin
            val_b_ff <= slot_val;
         end
      end
      if (state_ff == ST_EXEC) begin
         ok_ff    <= ok_c;
         sidx_ff  <= sidx_c;
         idout_ff <= idout_c;
      end
      if (load_rsp) begin
         rsp_data_ff <= {7'b0, empty_ff, 16'(idout_ff), sidx_ff, ok_ff};
      end
   end

   stf_ram #(
      .WIDTH(IdW),
      .DEPTH(stf_pkg::SLOT_COUNT)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (wr_port.en),
      .wr_addr(wr_port.addr),
      .wr_data(wr_port.data),
      .rd_addr(ptr_ff),
      .rd_data(rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `ASSERT_CLK(a_empty_range, clock, reset,
      empty_ff <= CntW'(stf_pkg::SLOT_COUNT), "empty count exceeds slot count")
   `ASSERT_CLK(a_write_phase, clock, reset,
      !wr_port.en || (state_ff == ST_EXEC) || (state_ff == ST_WR2),
      "slot RAM written outside the write-back phase")
   `ASSERT_CLK(a_cmp_phase, clock, reset,
      !cmp_vld_ff || (state_ff == ST_SCAN) || (state_ff == ST_DRAIN),
      "compare result arrives outside the table scan")
   `ASSERT_NEXT(a_accept_scan, clock, reset, req_fire,
      (state_ff == ST_SCAN) && (ptr_ff == '0), "accepted command does not start a scan")

endmodule

// ===== sv/stf_ram.sv =====
// Generic single write port RAM with one registered read port.
module stf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== verif/slot_table_first_free_top_tb.sv =====
// Self-checking testbench for the slot table with first-free allocation.
`timescale 1ns / 1ps

typedef struct packed {
   logic [3:0]      command;
   stf_pkg::id_type unit_id;
   logic [3:0]      index_a;
   logic [3:0]      index_b;
} table_command_type;

typedef struct packed {
   logic            ok;
   logic [3:0]      slot_index;
   stf_pkg::id_type unit_id_out;
   logic [3:0]      empty_count;
} table_reply_type;

class slot_table_mirror;
   stf_pkg::id_type slots [stf_pkg::SLOT_COUNT];
   table_reply_type expected_replies [$];
   int              mismatches;

   function new();
      mismatches = 0;
      clear_slots();
   endfunction

   function void clear_slots();
      foreach (slots[i]) slots[i] = '0;
   endfunction

   function int locate(stf_pkg::id_type id);
      if (id == '0) return stf_pkg::SLOT_COUNT;
      foreach (slots[i]) if (slots[i] == id) return i;
      return stf_pkg::SLOT_COUNT;
   endfunction

   function table_reply_type apply_command(table_command_type c);
      table_reply_type r;
      int              a;
      int              b;
      int              hit;
      bit              a_ok;
      bit              b_ok;
      stf_pkg::id_type held;
      r = '0;
      a = c.index_a;
      b = c.index_b;
      a_ok = a < stf_pkg::SLOT_COUNT;
      b_ok = b < stf_pkg::SLOT_COUNT;
      case (c.command)
         stf_pkg::CMD_ADD: begin
            if (c.unit_id != '0 && locate(c.unit_id) == stf_pkg::SLOT_COUNT) begin
               for (int i = 0; i < stf_pkg::SLOT_COUNT; i++) begin
                  if (slots[i] == '0) begin
                     slots[i] = c.unit_id;
                     r.ok = 1'b1;
                     r.slot_index = 4'(i);
                     break;
                  end
               end
            end
         end
         stf_pkg::CMD_ADD_AT: begin
            if (c.unit_id != '0 && a_ok && locate(c.unit_id) == stf_pkg::SLOT_COUNT) begin
               if (slots[a] == '0) begin
                  slots[a] = c.unit_id;
                  r.ok = 1'b1;
                  r.slot_index = 4'(a);
               end
            end
         end
         stf_pkg::CMD_MOVE: begin
            if (a_ok && b_ok && slots[a] != '0) begin
               if (a == b) begin
                  r.ok = 1'b1;
               end else if (slots[b] == '0) begin
                  slots[b] = slots[a];
                  slots[a] = '0;
                  r.ok = 1'b1;
               end
            end
         end
         stf_pkg::CMD_SWAP: begin
            if (a_ok && b_ok) begin
               if (a == b) begin
                  r.ok = slots[a] != '0;
               end else if (slots[a] != '0 || slots[b] != '0) begin
                  held = slots[a];
                  slots[a] = slots[b];
                  slots[b] = held;
                  r.ok = 1'b1;
               end
            end
         end
         stf_pkg::CMD_REMOVE_AT: begin
            if (a_ok) begin
               r.unit_id_out = slots[a];
               r.ok = slots[a] != '0;
               slots[a] = '0;
            end
         end
         stf_pkg::CMD_REMOVE_ID: begin
            hit = locate(c.unit_id);
            if (hit < stf_pkg::SLOT_COUNT) begin
               r.unit_id_out = slots[hit];
               slots[hit] = '0;
               r.ok = 1'b1;
            end
         end
         stf_pkg::CMD_FIND: begin
            hit = locate(c.unit_id);
            if (hit < stf_pkg::SLOT_COUNT) begin
               r.ok = 1'b1;
               r.slot_index = 4'(hit);
            end
         end
         stf_pkg::CMD_READ_SLOT: begin
            if (a_ok) begin
               r.ok = 1'b1;
               r.unit_id_out = slots[a];
            end
         end
         stf_pkg::CMD_CLEAR: begin
            clear_slots();
            r.ok = 1'b1;
         end
         default: begin
         end
      endcase
      foreach (slots[i]) if (slots[i] == '0) r.empty_count++;
      return r;
   endfunction

   function void note_command(table_command_type c);
      expected_replies.push_back(apply_command(c));
   endfunction

   function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatches++;
      end
   endfunction

   function void check_result(logic [31:0] data);
      table_reply_type want;
      if (expected_replies.size() == 0) begin
         $error("rsp transfer 0x%08h arrived with no command outstanding", data);
         mismatches++;
         return;
      end
      want = expected_replies.pop_front();
      compare_field("ok", want.ok, data[0]);
      compare_field("slot_index", want.slot_index, data[4:1]);
      compare_field("unit_id_out", want.unit_id_out, data[20:5]);
      compare_field("empty_count", want.empty_count, data[24:21]);
   endfunction
endclass

module slot_table_first_free_top_tb;

   localparam int         RANDOM_ITEMS   = 1600;
   localparam int         CYCLE_LIMIT    = 400000;
   localparam int         DRAIN_CYCLES   = 30;
   localparam logic [3:0] CMD_UNUSED_LO  = 4'd9;
   localparam logic [3:0] CMD_UNUSED_HI  = 4'd15;
   localparam logic [3:0] INDEX_TOP      = 4'd15;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [3:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   slot_table_mirror mirror;
   int unsigned      cycle_count;
   bit               req_quiet;
   bit               rsp_quiet;

   slot_table_first_free_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("slot_table_first_free_top regression: fail");
         $finish;
      end
   end

   // Idle gaps come in noisy stretches and in quiet stretches with none.
   function automatic int draw_gap(ref bit quiet);
      if ($urandom_range(0, 29) == 0) quiet = ~quiet;
      return quiet ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic drive_command(logic [3:0] cmd, stf_pkg::id_type id, logic [3:0] a,
                                logic [3:0] b);
      table_command_type c;
      int                gap;
      gap = draw_gap(req_quiet);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {b, a, id};
      do @(posedge clock); while (!req_tready);
      c.command = cmd;
      c.unit_id = id;
      c.index_a = a;
      c.index_b = b;
      mirror.note_command(c);
   endtask

   function automatic logic [3:0] pick_command();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 25) return stf_pkg::CMD_ADD;
      if (r < 37) return stf_pkg::CMD_ADD_AT;
      if (r < 47) return stf_pkg::CMD_MOVE;
      if (r < 57) return stf_pkg::CMD_SWAP;
      if (r < 66) return stf_pkg::CMD_REMOVE_AT;
      if (r < 75) return stf_pkg::CMD_REMOVE_ID;
      if (r < 85) return stf_pkg::CMD_FIND;
      if (r < 94) return stf_pkg::CMD_READ_SLOT;
      if (r < 96) return stf_pkg::CMD_CLEAR;
      return 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
   endfunction

   // Identifiers already in the table are favored so duplicates and hits occur.
   function automatic stf_pkg::id_type pick_id();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 60) return mirror.slots[$urandom_range(0, stf_pkg::SLOT_COUNT - 1)];
      return stf_pkg::id_type'($urandom_range(0, 65535));
   endfunction

   function automatic logic [3:0] pick_index();
      if ($urandom_range(0, 9) == 0) begin
         return 4'($urandom_range(stf_pkg::SLOT_COUNT, INDEX_TOP));
      end
      return 4'($urandom_range(0, stf_pkg::SLOT_COUNT - 1));
   endfunction

   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         gap = draw_gap(rsp_quiet);
         @(negedge clock);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         mirror.check_result(rsp_tdata);
      end
   end

   initial begin
      mirror      = new();
      cycle_count = 0;
      req_quiet   = 1'b0;
      rsp_quiet   = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      drive_command(stf_pkg::CMD_ADD, 16'h0000, 4'd0, 4'd0);
      for (int i = 0; i < stf_pkg::SLOT_COUNT; i++) begin
         drive_command(stf_pkg::CMD_ADD, 16'hFFFF >> i, INDEX_TOP, INDEX_TOP);
      end
      drive_command(stf_pkg::CMD_ADD, 16'h1234, 4'd0, 4'd0);
      drive_command(stf_pkg::CMD_REMOVE_AT, 16'h0000, INDEX_TOP, 4'd0);
      drive_command(stf_pkg::CMD_REMOVE_AT, 16'h0000, 4'd2, 4'd0);
      drive_command(stf_pkg::CMD_REMOVE_AT, 16'h0000, 4'd2, 4'd0);
      drive_command(stf_pkg::CMD_ADD, 16'h7FFF, 4'd0, 4'd0);
      drive_command(stf_pkg::CMD_ADD_AT, 16'h1234, 4'd3, 4'd0);
      drive_command(stf_pkg::CMD_ADD_AT, 16'h1234, 4'd8, 4'd0);
      drive_command(stf_pkg::CMD_ADD_AT, 16'h1234, 4'd2, 4'd0);
      drive_command(stf_pkg::CMD_REMOVE_AT, 16'h0000, 4'd5, 4'd0);
      drive_command(stf_pkg::CMD_MOVE, 16'h0000, 4'd5, 4'd6);
      drive_command(stf_pkg::CMD_MOVE, 16'h0000, 4'd6, 4'd5);
      drive_command(stf_pkg::CMD_MOVE, 16'h0000, 4'd3, 4'd3);
      drive_command(stf_pkg::CMD_MOVE, 16'h0000, 4'd3, 4'd4);
      drive_command(stf_pkg::CMD_SWAP, 16'h0000, 4'd6, 4'd6);
      drive_command(stf_pkg::CMD_SWAP, 16'h0000, 4'd6, 4'd0);
      drive_command(stf_pkg::CMD_SWAP, 16'h0000, 4'd9, 4'd0);
      drive_command(stf_pkg::CMD_REMOVE_ID, 16'hFFFF, 4'd0, 4'd0);
      drive_command(stf_pkg::CMD_REMOVE_ID, 16'h0000, 4'd0, 4'd0);
      drive_command(stf_pkg::CMD_FIND, 16'h1234, 4'd0, 4'd0);
      drive_command(stf_pkg::CMD_FIND, 16'h0000, 4'd0, 4'd0);
      drive_command(stf_pkg::CMD_READ_SLOT, 16'h0000, 4'd6, 4'd0);
      drive_command(stf_pkg::CMD_READ_SLOT, 16'h0000, 4'd12, 4'd0);
      drive_command(CMD_UNUSED_LO, 16'h1234, 4'd0, 4'd1);
      drive_command(CMD_UNUSED_HI, 16'hABCD, 4'd1, 4'd0);
      drive_command(stf_pkg::CMD_CLEAR, 16'h0000, 4'd0, 4'd0);
      drive_command(stf_pkg::CMD_SWAP, 16'h0000, 4'd1, 4'd2);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         drive_command(pick_command(), pick_id(), pick_index(), pick_index());
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (mirror.expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0) begin
         $display("slot_table_first_free_top regression: pass");
      end else begin
         $display("slot_table_first_free_top regression: fail");
      end
      $finish;
   end

endmodule
